### rtl/wrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrr_pkg
// Shared constants for the water ripple height field block.
// ----------------------------------------------------------------------------
package wrr_pkg;

	localparam int GRID_WIDTH  = 64;
	localparam int GRID_HEIGHT = 64;
	localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W      = $clog2(CELLS);
	localparam int COL_W       = $clog2(GRID_WIDTH);
	localparam int OFF_W       = 20 + COL_W;

	localparam int HEIGHT_W = 16;
	localparam int PIXEL_W  = 32;
	localparam int COORD_W  = 6;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_DROP = 2'd1;
	localparam logic [1:0] FUNC_STEP = 2'd2;
	localparam logic [1:0] FUNC_READ = 2'd3;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_DEPTH  = 2'd1;
	localparam logic [1:0] REG_SHIFT  = 2'd2;

endpackage

### rtl/wrr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/water_ripple_height_field.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_ripple_height_field
// Two-buffer water ripple: height grids, drop stamping, spread and refraction.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low; each item yields one
// result on done for a single cycle and the receiver cannot stall. After reset
// the block clears all CELLS (4096) cells of both height grids, one cell per
// cycle, with busy high. An accepted drop walks the (2R+1)x(2R+1) square around
// the drop and writes each cell inside the disc. A step walks the W*(H-2)
// interior cells twice over the single read port of the height grid: once in
// the spread pass and once in the render pass.
// ----------------------------------------------------------------------------
module water_ripple_height_field (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [11:0] cell_index,
	input  logic [31:0] pixel_in,
	input  logic [5:0]  drop_x,
	input  logic [5:0]  drop_y,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [31:0] pixel_out,
	output logic        drop_ignored
);

	localparam int AW = wrr_pkg::ADDR_W;
	localparam int OW = wrr_pkg::OFF_W;
	localparam int HW = wrr_pkg::HEIGHT_W;

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DROP   = 3'd2;
	localparam logic [2:0] ST_SPREAD = 3'd3;
	localparam logic [2:0] ST_RENDER = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;

	localparam logic [AW-1:0] FIRST = AW'(wrr_pkg::GRID_WIDTH);
	localparam logic [AW-1:0] LAST  = AW'(wrr_pkg::CELLS - wrr_pkg::GRID_WIDTH - 1);
	localparam logic [AW-1:0] ROWSTEP = AW'(wrr_pkg::GRID_WIDTH);

	logic [2:0]    state_q;
	logic [2:0]    ph_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] clr_q;
	logic          bank_q;
	logic [3:0]    radius_q;
	logic [HW-1:0] depth_q;
	logic [3:0]    shift_q;
	logic [4:0]    dx_q;
	logic [4:0]    dy_q;
	logic          zero_q;
	logic [5:0]    x0_q;
	logic [5:0]    y0_q;
	logic          rd_ok_q;

	logic signed [HW-1:0] n0_q, n1_q, n2_q, pv_q, v_q;
	logic [AW-1:0] tgt_q;

	logic          done_q;
	logic [31:0]   pix_q;
	logic          ign_q;

	logic          accept;
	logic          drop_bad;
	logic [10:0]   xr, yr;

	logic signed [HW-1:0] cur_rd, old_rd;
	logic [HW-1:0] ga_rd, gb_rd;
	logic [AW-1:0] cur_raddr;
	logic          cur_we, old_we, ga_we, gb_we;
	logic [AW-1:0] g_waddr;
	logic [HW-1:0] g_wdata;

	logic signed [5:0]  ox, oy;
	logic signed [11:0] ex, ey;
	logic [9:0]    d2;
	logic [7:0]    r2;
	logic          in_disc;
	logic [4:0]    span;
	logic [AW-1:0] drop_addr;
	logic [HW-1:0] drop_val;
	logic [HW-1:0] damp_val;

	logic signed [17:0] s_sum;
	logic signed [17:0] s_half;
	logic signed [OW-1:0] dv, dh, tgt;
	logic          tgt_ok;

	logic          src_we, shown_we;
	logic [AW-1:0] shown_waddr;
	logic [31:0]   shown_wdata;
	logic [31:0]   src_rd, shown_rd;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	assign xr = 11'(drop_x) + 11'(radius_q);
	assign yr = 11'(drop_y) + 11'(radius_q);
	assign drop_bad = (xr >= 11'(wrr_pkg::GRID_WIDTH)) || (yr >= 11'(wrr_pkg::GRID_HEIGHT))
		|| (drop_x <= {2'b00, radius_q}) || (drop_y <= {2'b00, radius_q});

	// disc geometry
	assign ox   = $signed({2'b00, radius_q}) - $signed({1'b0, dx_q});
	assign oy   = $signed({2'b00, radius_q}) - $signed({1'b0, dy_q});
	assign ex   = 12'(ox);
	assign ey   = 12'(oy);
	assign d2   = 10'(ex * ex) + 10'(ey * ey);
	assign r2   = 8'(radius_q) * 8'(radius_q);
	assign in_disc = ({2'b00, r2} >= d2);
	assign span = {radius_q, 1'b0};
	assign drop_addr = AW'((AW'(y0_q) + AW'(dy_q)) * wrr_pkg::GRID_WIDTH)
		+ AW'(x0_q) + AW'(dx_q);
	assign drop_val = zero_q ? '0 : (depth_q - ((radius_q == 4'd1) ? HW'(d2) : '0));

	assign damp_val = v_q - (v_q >>> shift_q);

	assign s_sum  = 18'(n0_q) + 18'(n1_q) + 18'(n2_q) + 18'(cur_rd);
	assign s_half = s_sum >>> 1;

	assign dv  = OW'(n0_q) - OW'(n1_q);
	assign dh  = OW'(n2_q) - OW'(cur_rd);
	assign tgt = $signed({{(OW-AW){1'b0}}, idx_q}) + OW'(dv * wrr_pkg::GRID_WIDTH) + dh;
	assign tgt_ok = (tgt > 0) && (tgt < OW'(wrr_pkg::CELLS));

	always_comb begin
		case (ph_q)
			3'd0:    cur_raddr = (state_q == ST_RENDER) ? idx_q - ROWSTEP : idx_q - 1'b1;
			3'd1:    cur_raddr = (state_q == ST_RENDER) ? idx_q + ROWSTEP : idx_q - ROWSTEP;
			3'd2:    cur_raddr = (state_q == ST_RENDER) ? idx_q - 1'b1 : idx_q + 1'b1;
			3'd3:    cur_raddr = (state_q == ST_RENDER) ? idx_q + 1'b1 : idx_q + ROWSTEP;
			default: cur_raddr = idx_q;
		endcase
	end

	assign cur_we = (state_q == ST_DROP) && (zero_q || in_disc);
	assign old_we = (state_q == ST_SPREAD) && (ph_q == 3'd5);
	assign ga_we  = (state_q == ST_CLR) || (bank_q ? old_we : cur_we);
	assign gb_we  = (state_q == ST_CLR) || (bank_q ? cur_we : old_we);

	always_comb begin
		case (state_q)
			ST_CLR: begin
				g_waddr = clr_q;
				g_wdata = '0;
			end
			ST_DROP: begin
				g_waddr = drop_addr;
				g_wdata = drop_val;
			end
			default: begin
				g_waddr = idx_q;
				g_wdata = damp_val;
			end
		endcase
	end

	assign cur_rd = bank_q ? gb_rd : ga_rd;
	assign old_rd = bank_q ? ga_rd : gb_rd;

	wrr_ram #(.WIDTH(HW), .DEPTH(wrr_pkg::CELLS)) u_grid_a (
		.clk(clk), .we(ga_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(bank_q ? idx_q : cur_raddr), .rdata(ga_rd)
	);

	wrr_ram #(.WIDTH(HW), .DEPTH(wrr_pkg::CELLS)) u_grid_b (
		.clk(clk), .we(gb_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(bank_q ? cur_raddr : idx_q), .rdata(gb_rd)
	);

	assign src_we      = accept && (func == wrr_pkg::FUNC_LOAD)
		&& (13'(cell_index) < 13'(wrr_pkg::CELLS));
	assign shown_we    = src_we || ((state_q == ST_RENDER) && (ph_q == 3'd6));
	assign shown_waddr = src_we ? AW'(cell_index) : idx_q;
	assign shown_wdata = src_we ? pixel_in : src_rd;

	wrr_ram #(.WIDTH(wrr_pkg::PIXEL_W), .DEPTH(wrr_pkg::CELLS)) u_source (
		.clk(clk), .we(src_we), .waddr(AW'(cell_index)), .wdata(pixel_in),
		.raddr(tgt_q), .rdata(src_rd)
	);

	wrr_ram #(.WIDTH(wrr_pkg::PIXEL_W), .DEPTH(wrr_pkg::CELLS)) u_shown (
		.clk(clk), .we(shown_we), .waddr(shown_waddr), .wdata(shown_wdata),
		.raddr(AW'(cell_index)), .rdata(shown_rd)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 4'd3;
			depth_q  <= 16'd100;
			shift_q  <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				wrr_pkg::REG_RADIUS: radius_q <= cfg_data[3:0];
				wrr_pkg::REG_DEPTH:  depth_q  <= cfg_data;
				wrr_pkg::REG_SHIFT:  shift_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			ph_q    <= '0;
			idx_q   <= '0;
			clr_q   <= '0;
			bank_q  <= 1'b0;
			dx_q    <= '0;
			dy_q    <= '0;
			zero_q  <= 1'b0;
			done_q  <= 1'b0;
			ign_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(wrr_pkg::CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (func)
							wrr_pkg::FUNC_LOAD: begin
								done_q <= 1'b1;
								ign_q  <= 1'b0;
							end
							wrr_pkg::FUNC_DROP: begin
								if (drop_bad) begin
									done_q <= 1'b1;
									ign_q  <= 1'b1;
								end else begin
									state_q <= ST_DROP;
									zero_q  <= 1'b1;
									dx_q    <= '0;
									dy_q    <= '0;
								end
							end
							wrr_pkg::FUNC_STEP: begin
								state_q <= ST_SPREAD;
								idx_q   <= FIRST;
								ph_q    <= '0;
							end
							default: begin
								state_q <= ST_READ;
							end
						endcase
					end
				end
				ST_DROP: begin
					if (zero_q) begin
						zero_q <= 1'b0;
					end else if (dx_q == span) begin
						dx_q <= '0;
						if (dy_q == span) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
							ign_q   <= 1'b0;
						end else begin
							dy_q <= dy_q + 1'b1;
						end
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
				ST_SPREAD: begin
					if (ph_q == 3'd5) begin
						ph_q <= '0;
						if (idx_q == LAST) begin
							state_q <= ST_RENDER;
							bank_q  <= ~bank_q;
							idx_q   <= FIRST;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_RENDER: begin
					if (ph_q == 3'd6) begin
						ph_q <= '0;
						if (idx_q == LAST) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
							ign_q   <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					ign_q   <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q    <= drop_x - {2'b00, radius_q};
			y0_q    <= drop_y - {2'b00, radius_q};
			rd_ok_q <= (func == wrr_pkg::FUNC_READ) && (13'(cell_index) < 13'(wrr_pkg::CELLS));
		end
		case (ph_q)
			3'd1: begin
				n0_q <= cur_rd;
				pv_q <= old_rd;
			end
			3'd2: n1_q <= cur_rd;
			3'd3: n2_q <= cur_rd;
			3'd4: begin
				v_q   <= HW'(s_half - 18'(pv_q));
				tgt_q <= tgt_ok ? AW'(tgt) : idx_q;
			end
			default: ;
		endcase
		if (state_q == ST_READ) begin
			pix_q <= rd_ok_q ? shown_rd : '0;
		end else if (state_q != ST_IDLE || accept) begin
			pix_q <= '0;
		end
	end

	assign done         = done_q;
	assign pixel_out    = pix_q;
	assign drop_ignored = ign_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> busy)
		else $error("item taken during grid clear");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted item neither busy nor done");

	a_spread_addr: assert property (@(posedge clk) disable iff (!arst_n)
		old_we |-> (idx_q >= FIRST && idx_q <= LAST))
		else $error("spread write outside interior");

	a_one_grid_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPREAD || state_q == ST_RENDER) |-> !(ga_we && gb_we))
		else $error("both grids written during step");

endmodule
